### hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define TSF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define TSF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/tsf_pkg.sv
// Types, constants and helper functions for the trigonal Schmid factor pipeline.
`default_nettype none

package tsf_pkg;

    localparam int NOPS         = 6;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 32;
    localparam int CORDIC_STEPS = 24;
    localparam int FRONT_LAT    = 3;
    localparam int SEL_LAT      = 4;
    localparam int ACOS_LAT     = 2 + SQRT_STEPS + CORDIC_STEPS;
    localparam int PIPE_LAT     = FRONT_LAT + SQRT_STEPS + DIV_STEPS + SEL_LAT + ACOS_LAT;

    localparam logic [30:0] COS_ONE   = 31'h4000_0000;
    localparam logic [14:0] ANGLE_MAX = 15'd25736;

    localparam logic signed [17:0] Q_HALF = 18'sd32768;
    localparam logic signed [17:0] Q_R3H  = 18'sd56756;
    localparam logic signed [17:0] Q_ONE  = 18'sd65536;

    typedef logic signed [15:0] comp_t;
    typedef comp_t [2:0] vec3_t;
    typedef logic signed [31:0] outer_elem_t;
    typedef outer_elem_t [8:0] outer_t;
    typedef logic signed [17:0] coef_t;
    typedef coef_t [8:0] mat_t;
    typedef logic signed [53:0] dot_t;
    typedef logic [47:0] mag_t;
    typedef mag_t [NOPS-1:0] mag_vec_t;
    typedef logic [31:0] quot_t;
    typedef quot_t [NOPS-1:0] quot_vec_t;
    typedef logic [30:0] cos_t;
    typedef logic [60:0] prod_t;
    typedef logic [14:0] angle_t;

    typedef struct packed {
        logic try_lo;
        logic try_hi;
        logic zero_n;
        logic zero_d;
    } flags_t;

    typedef struct packed {
        prod_t      prod;
        logic [2:0] idx;
        cos_t       cp;
        cos_t       cd;
    } cand_t;

    typedef struct packed {
        logic [15:0] fac;
        logic [2:0]  idx;
        logic        found;
    } side_t;

    // Operator matrix, row major; only entries 0, 1, 3, 4 and 8 are ever nonzero.
    function automatic mat_t sym_mat(input int op);
        mat_t m;
        m = '0;
        case (op)
            0: begin
                m[0] = Q_ONE;   m[1] = '0;      m[3] = '0;      m[4] = Q_ONE;   m[8] = Q_ONE;
            end
            1: begin
                m[0] = -Q_HALF; m[1] = Q_R3H;   m[3] = -Q_R3H;  m[4] = -Q_HALF; m[8] = Q_ONE;
            end
            2: begin
                m[0] = -Q_HALF; m[1] = -Q_R3H;  m[3] = Q_R3H;   m[4] = -Q_HALF; m[8] = Q_ONE;
            end
            3: begin
                m[0] = Q_HALF;  m[1] = Q_R3H;   m[3] = Q_R3H;   m[4] = -Q_HALF; m[8] = -Q_ONE;
            end
            4: begin
                m[0] = -Q_ONE;  m[1] = '0;      m[3] = '0;      m[4] = Q_ONE;   m[8] = -Q_ONE;
            end
            5: begin
                m[0] = Q_HALF;  m[1] = -Q_R3H;  m[3] = -Q_R3H;  m[4] = -Q_HALF; m[8] = -Q_ONE;
            end
            default: m = '0;
        endcase
        return m;
    endfunction

    // l . (M v) from the outer product l_i * v_j, Q16.
    function automatic dot_t sym_dot(input int op, input outer_t p);
        mat_t m;
        dot_t acc;
        m   = sym_mat(op);
        acc = '0;
        for (int k = 0; k < 9; k++) begin
            acc = acc + (dot_t'(m[k]) * dot_t'(p[k]));
        end
        return acc;
    endfunction

    // atan(2^-i) in radians, Q.24
    function automatic logic signed [27:0] atan_q24(input int i);
        case (i)
            0:  return 28'sd13176795;
            1:  return 28'sd7778716;
            2:  return 28'sd4110060;
            3:  return 28'sd2086331;
            4:  return 28'sd1047214;
            5:  return 28'sd524117;
            6:  return 28'sd262123;
            7:  return 28'sd131069;
            8:  return 28'sd65536;
            9:  return 28'sd32768;
            10: return 28'sd16384;
            11: return 28'sd8192;
            12: return 28'sd4096;
            13: return 28'sd2048;
            14: return 28'sd1024;
            15: return 28'sd512;
            16: return 28'sd256;
            17: return 28'sd128;
            18: return 28'sd64;
            19: return 28'sd32;
            20: return 28'sd16;
            21: return 28'sd8;
            22: return 28'sd4;
            23: return 28'sd2;
            default: return 28'sd0;
        endcase
    endfunction

endpackage

`default_nettype wire

### hw/rtl/trigonal_schmid_factor.sv
// Top level of the trigonal Schmid factor pipeline.
`default_nettype none

// Takes one load/plane/direction triple per cycle and returns, for each, the
// largest Schmid factor over the trigonal operators allowed by the sign of
// plane z, the first operator index reaching it and the arc cosines of its two
// cosines. Sustained rate is one item per clock. The pipeline runs through the
// 32-stage square root of the magnitude products, the 32-stage divider that
// forms the twelve cosines, and the arc cosine unit (32-stage square root plus
// 24 CORDIC stages). The whole pipeline holds while the output register
// carries a result that has not been taken; input ready then drops.
module trigonal_schmid_factor (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire tsf_pkg::comp_t load_x,
    input  wire tsf_pkg::comp_t load_y,
    input  wire tsf_pkg::comp_t load_z,
    input  wire tsf_pkg::comp_t plane_x,
    input  wire tsf_pkg::comp_t plane_y,
    input  wire tsf_pkg::comp_t plane_z,
    input  wire tsf_pkg::comp_t dir_x,
    input  wire tsf_pkg::comp_t dir_y,
    input  wire tsf_pkg::comp_t dir_z,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [15:0]         factor,
    output logic [2:0]          slip_index,
    output tsf_pkg::angle_t     phi_angle,
    output tsf_pkg::angle_t     lambda_angle
);
    import tsf_pkg::*;

    logic                en;
    logic [PIPE_LAT-1:0] vld_reg;
    logic                out_vld_reg;

    vec3_t       l_reg, n_reg, d_reg;
    outer_t      pn_reg, pd_reg, pn_next, pd_next;
    logic [31:0] ln_reg, nn_reg, dn_reg;
    logic        try_lo_reg, try_hi_reg;
    logic [63:0] prodn_reg, prodd_reg;
    mag_vec_t    magn_reg, magd_reg, magn_next, magd_next;
    logic [1:0]  try3_reg;

    mag_vec_t    magn_dly_reg [SQRT_STEPS];
    mag_vec_t    magd_dly_reg [SQRT_STEPS];
    logic [1:0]  try_dly_reg [SQRT_STEPS];
    quot_t       lp, ld;
    flags_t      flags_in;
    flags_t      flag_dly_reg [DIV_STEPS];
    quot_vec_t   qn, qd;

    cos_t        cp_reg [NOPS];
    cos_t        cd_reg [NOPS];
    cos_t        cp_next [NOPS];
    cos_t        cd_next [NOPS];
    prod_t       prod6_reg [NOPS];
    cos_t        cp6_reg [NOPS];
    cos_t        cd6_reg [NOPS];
    cand_t       pair_reg [3];
    cand_t       pair_next [3];
    cand_t       best_reg, best_next;
    side_t       side_next;
    side_t       side_reg;
    side_t       side_dly_reg [ACOS_LAT];
    angle_t      phi_a, lambda_a;

    logic [15:0] factor_reg;
    logic [2:0]  idx_reg;
    angle_t      phi_reg, lambda_reg;

    function automatic logic [31:0] norm2(input vec3_t v);
        logic signed [31:0] s0, s1, s2;
        s0 = v[0] * v[0];
        s1 = v[1] * v[1];
        s2 = v[2] * v[2];
        return $unsigned(s0) + $unsigned(s1) + $unsigned(s2);
    endfunction

    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;

    // valid bits march with the data; the whole pipe holds on a stall
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[PIPE_LAT-2:0], in_valid};
            out_vld_reg <= vld_reg[PIPE_LAT-1];
        end
    end

    // front: capture, outer products and norms, dots and magnitude products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                pn_next[i*3+j] = l_reg[i] * n_reg[j];
                pd_next[i*3+j] = l_reg[i] * d_reg[j];
            end
        end
    end

    always_comb begin
        dot_t dn, dd;
        for (int op = 0; op < NOPS; op++) begin
            dn            = sym_dot(op, pn_reg);
            dd            = sym_dot(op, pd_reg);
            dn            = dn[53] ? -dn : dn;
            dd            = dd[53] ? -dd : dd;
            magn_next[op] = dn[47:0];
            magd_next[op] = dd[47:0];
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            l_reg      <= {load_z, load_y, load_x};
            n_reg      <= {plane_z, plane_y, plane_x};
            d_reg      <= {dir_z, dir_y, dir_x};

            pn_reg     <= pn_next;
            pd_reg     <= pd_next;
            ln_reg     <= norm2(l_reg);
            nn_reg     <= norm2(n_reg);
            dn_reg     <= norm2(d_reg);
            // upper operators flip z, so they need plane z at most zero
            try_lo_reg <= !n_reg[2][15];
            try_hi_reg <= n_reg[2][15] || (n_reg[2] == '0);

            prodn_reg  <= 64'(ln_reg) * 64'(nn_reg);
            prodd_reg  <= 64'(ln_reg) * 64'(dn_reg);
            magn_reg   <= magn_next;
            magd_reg   <= magd_next;
            try3_reg   <= {try_lo_reg, try_hi_reg};
        end
    end

    tsf_isqrt u_sqrt_n (
        .clk  (clk),
        .en   (en),
        .arg  (prodn_reg),
        .root (lp)
    );

    tsf_isqrt u_sqrt_d (
        .clk  (clk),
        .en   (en),
        .arg  (prodd_reg),
        .root (ld)
    );

    always_ff @(posedge clk) begin
        if (en) begin
            magn_dly_reg[0] <= magn_reg;
            magd_dly_reg[0] <= magd_reg;
            try_dly_reg[0]  <= try3_reg;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                magn_dly_reg[k] <= magn_dly_reg[k-1];
                magd_dly_reg[k] <= magd_dly_reg[k-1];
                try_dly_reg[k]  <= try_dly_reg[k-1];
            end
        end
    end

    tsf_div u_div_n (
        .clk     (clk),
        .en      (en),
        .divisor (lp),
        .mag     (magn_dly_reg[SQRT_STEPS-1]),
        .quot    (qn)
    );

    tsf_div u_div_d (
        .clk     (clk),
        .en      (en),
        .divisor (ld),
        .mag     (magd_dly_reg[SQRT_STEPS-1]),
        .quot    (qd)
    );

    always_comb begin
        flags_in.try_lo = try_dly_reg[SQRT_STEPS-1][1];
        flags_in.try_hi = try_dly_reg[SQRT_STEPS-1][0];
        flags_in.zero_n = (lp == '0);
        flags_in.zero_d = (ld == '0);
    end

    always_ff @(posedge clk) begin
        if (en) begin
            flag_dly_reg[0] <= flags_in;
            for (int k = 1; k < DIV_STEPS; k++) begin
                flag_dly_reg[k] <= flag_dly_reg[k-1];
            end
        end
    end

    // saturate cosines; an operator not tried reads as zero
    always_comb begin
        flags_t f;
        logic   tried;
        f = flag_dly_reg[DIV_STEPS-1];
        for (int op = 0; op < NOPS; op++) begin
            tried = (op < NOPS / 2) ? f.try_lo : f.try_hi;
            if (!tried || f.zero_n) begin
                cp_next[op] = '0;
            end else if (qn[op] > 32'(COS_ONE)) begin
                cp_next[op] = COS_ONE;
            end else begin
                cp_next[op] = qn[op][30:0];
            end
            if (!tried || f.zero_d) begin
                cd_next[op] = '0;
            end else if (qd[op] > 32'(COS_ONE)) begin
                cd_next[op] = COS_ONE;
            end else begin
                cd_next[op] = qd[op][30:0];
            end
        end
    end

    // first pass of the max: pairs, later index wins only when strictly larger
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (prod6_reg[2*k+1] > prod6_reg[2*k]) begin
                pair_next[k].prod = prod6_reg[2*k+1];
                pair_next[k].idx  = 3'(2 * k + 1);
                pair_next[k].cp   = cp6_reg[2*k+1];
                pair_next[k].cd   = cd6_reg[2*k+1];
            end else begin
                pair_next[k].prod = prod6_reg[2*k];
                pair_next[k].idx  = 3'(2 * k);
                pair_next[k].cp   = cp6_reg[2*k];
                pair_next[k].cd   = cd6_reg[2*k];
            end
        end
    end

    always_comb begin
        best_next = pair_reg[0];
        if (pair_reg[1].prod > best_next.prod) begin
            best_next = pair_reg[1];
        end
        if (pair_reg[2].prod > best_next.prod) begin
            best_next = pair_reg[2];
        end
    end

    always_comb begin
        logic [61:0] fsum;
        fsum            = {1'b0, best_reg.prod} + (62'd1 << 43);
        side_next.fac   = (fsum[61:44] > 18'd65535) ? 16'hFFFF : fsum[59:44];
        side_next.idx   = best_reg.idx;
        side_next.found = (best_reg.prod != '0);
    end

    always_ff @(posedge clk) begin
        if (en) begin
            for (int op = 0; op < NOPS; op++) begin
                logic [61:0] p;
                cp_reg[op]    <= cp_next[op];
                cd_reg[op]    <= cd_next[op];
                p              = cp_reg[op] * cd_reg[op];
                prod6_reg[op] <= p[60:0];
                cp6_reg[op]   <= cp_reg[op];
                cd6_reg[op]   <= cd_reg[op];
            end
            pair_reg <= pair_next;
            best_reg <= best_next;
        end
    end

    tsf_acos u_acos_phi (
        .clk   (clk),
        .en    (en),
        .c     (best_reg.cp),
        .angle (phi_a)
    );

    tsf_acos u_acos_lambda (
        .clk   (clk),
        .en    (en),
        .c     (best_reg.cd),
        .angle (lambda_a)
    );

    always_ff @(posedge clk) begin
        if (en) begin
            side_dly_reg[0] <= side_next;
            for (int k = 1; k < ACOS_LAT; k++) begin
                side_dly_reg[k] <= side_dly_reg[k-1];
            end
        end
    end

    assign side_reg = side_dly_reg[ACOS_LAT-1];

    // output register
    always_ff @(posedge clk) begin
        if (en) begin
            factor_reg <= side_reg.fac;
            idx_reg    <= side_reg.idx;
            phi_reg    <= side_reg.found ? phi_a : '0;
            lambda_reg <= side_reg.found ? lambda_a : '0;
        end
    end

    assign out_valid    = out_vld_reg;
    assign factor       = factor_reg;
    assign slip_index   = idx_reg;
    assign phi_angle    = phi_reg;
    assign lambda_angle = lambda_reg;

endmodule

`default_nettype wire

### hw/rtl/tsf_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module tsf_isqrt (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] arg,
    output logic [31:0]      root
);
    import tsf_pkg::*;

    logic [63:0] v_reg [SQRT_STEPS-1];
    logic [63:0] r_reg [SQRT_STEPS];
    logic [63:0] v_stage [SQRT_STEPS];
    logic [63:0] r_stage [SQRT_STEPS];
    logic [63:0] v_next [SQRT_STEPS];
    logic [63:0] r_next [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_in
        if (k == 0) begin : g_first
            assign v_stage[k] = arg;
            assign r_stage[k] = '0;
        end else begin : g_rest
            assign v_stage[k] = v_reg[k-1];
            assign r_stage[k] = r_reg[k-1];
        end
    end

    always_comb begin
        logic [63:0] bit_val;
        logic [64:0] trial;
        for (int k = 0; k < SQRT_STEPS; k++) begin
            bit_val = 64'd1 << (62 - 2 * k);
            trial   = {1'b0, r_stage[k]} + {1'b0, bit_val};
            if ({1'b0, v_stage[k]} >= trial) begin
                v_next[k] = v_stage[k] - trial[63:0];
                r_next[k] = (r_stage[k] >> 1) + bit_val;
            end else begin
                v_next[k] = v_stage[k];
                r_next[k] = r_stage[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            for (int k = 0; k < SQRT_STEPS - 1; k++) begin
                v_reg[k] <= v_next[k];
            end
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_reg[k] <= r_next[k];
            end
        end
    end

    assign root = r_reg[SQRT_STEPS-1][31:0];

endmodule

`default_nettype wire

### hw/rtl/tsf_div.sv
// Pipelined restoring divider: six numerators over one shared divisor.
`default_nettype none

module tsf_div (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire tsf_pkg::quot_t    divisor,
    input  wire tsf_pkg::mag_vec_t mag,
    output tsf_pkg::quot_vec_t     quot
);
    import tsf_pkg::*;

    quot_t       p_reg [DIV_STEPS-1];
    quot_t       p_stage [DIV_STEPS];
    logic [63:0] acc_reg [DIV_STEPS][NOPS];
    logic [63:0] acc_stage [DIV_STEPS][NOPS];
    logic [63:0] acc_next [DIV_STEPS][NOPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_in
        if (k == 0) begin : g_first
            assign p_stage[k] = divisor;
            for (genvar j = 0; j < NOPS; j++) begin : g_lane
                // numerator is |dot| << 14
                assign acc_stage[k][j] = {2'b00, mag[j], 14'b0};
            end
        end else begin : g_rest
            assign p_stage[k] = p_reg[k-1];
            for (genvar j = 0; j < NOPS; j++) begin : g_lane
                assign acc_stage[k][j] = acc_reg[k-1][j];
            end
        end
    end

    // Remainder rides in the upper half, quotient bits shift in at the bottom.
    always_comb begin
        logic [32:0] top;
        for (int k = 0; k < DIV_STEPS; k++) begin
            for (int j = 0; j < NOPS; j++) begin
                top = acc_stage[k][j][63:31];
                if (top >= {1'b0, p_stage[k]}) begin
                    top            = top - {1'b0, p_stage[k]};
                    acc_next[k][j] = {top[31:0], acc_stage[k][j][30:0], 1'b1};
                end else begin
                    acc_next[k][j] = {top[31:0], acc_stage[k][j][30:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            for (int k = 0; k < DIV_STEPS - 1; k++) begin
                p_reg[k] <= p_stage[k];
            end
            acc_reg <= acc_next;
        end
    end

    always_comb begin
        for (int j = 0; j < NOPS; j++) begin
            quot[j] = acc_reg[DIV_STEPS-1][j][31:0];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tsf_acos.sv
// Pipelined arc cosine: square, square root, then CORDIC vectoring.
`default_nettype none

module tsf_acos (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire tsf_pkg::cos_t   c,
    output tsf_pkg::angle_t      angle
);
    import tsf_pkg::*;

    logic [61:0]        sq_reg;
    cos_t               c_reg;
    cos_t               c_dly_reg [SQRT_STEPS];
    logic [63:0]        sqrt_arg;
    logic [31:0]        root;
    logic signed [32:0] x_reg [CORDIC_STEPS];
    logic signed [32:0] y_reg [CORDIC_STEPS];
    logic signed [27:0] z_reg [CORDIC_STEPS];
    logic signed [32:0] x_stage [CORDIC_STEPS];
    logic signed [32:0] y_stage [CORDIC_STEPS];
    logic signed [27:0] z_stage [CORDIC_STEPS];
    logic signed [32:0] x_next [CORDIC_STEPS];
    logic signed [32:0] y_next [CORDIC_STEPS];
    logic signed [27:0] z_next [CORDIC_STEPS];
    angle_t             angle_reg;
    angle_t             angle_next;

    // shift that truncates toward zero
    function automatic logic signed [32:0] shr_tz(input logic signed [32:0] v, input int s);
        logic [32:0] a;
        a = v[32] ? -v : v;
        a = a >> s;
        return v[32] ? -$signed(a) : $signed(a);
    endfunction

    always_ff @(posedge clk) begin
        if (en) begin
            sq_reg       <= c * c;
            c_reg        <= c;
            c_dly_reg[0] <= c_reg;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                c_dly_reg[k] <= c_dly_reg[k-1];
            end
        end
    end

    assign sqrt_arg = (64'd1 << 60) - {2'b00, sq_reg};

    tsf_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .arg  (sqrt_arg),
        .root (root)
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_in
        if (i == 0) begin : g_first
            assign x_stage[i] = $signed({2'b00, c_dly_reg[SQRT_STEPS-1]});
            assign y_stage[i] = $signed({1'b0, root});
            assign z_stage[i] = '0;
        end else begin : g_rest
            assign x_stage[i] = x_reg[i-1];
            assign y_stage[i] = y_reg[i-1];
            assign z_stage[i] = z_reg[i-1];
        end
    end

    always_comb begin
        logic signed [32:0] xs;
        logic signed [32:0] ys;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = shr_tz(x_stage[i], i);
            ys = shr_tz(y_stage[i], i);
            if (y_stage[i] > 0) begin
                x_next[i] = x_stage[i] + ys;
                y_next[i] = y_stage[i] - xs;
                z_next[i] = z_stage[i] + atan_q24(i);
            end else begin
                x_next[i] = x_stage[i] - ys;
                y_next[i] = y_stage[i] + xs;
                z_next[i] = z_stage[i] - atan_q24(i);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
            end
        end
    end

    // round Q.24 to Q1.14 and clamp to pi/2
    always_comb begin
        logic signed [27:0] z;
        logic signed [27:0] zr;
        z  = z_reg[CORDIC_STEPS-1];
        zr = (z + 28'sd512) >>> 10;
        if (z <= 0) begin
            angle_next = '0;
        end else if (zr > $signed({13'b0, ANGLE_MAX})) begin
            angle_next = ANGLE_MAX;
        end else begin
            angle_next = zr[14:0];
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

`default_nettype wire

### hw/rtl/tsf_check.sv
// Port-level checker for the trigonal Schmid factor block, bound to the top.
`default_nettype none
`include "assert_macros.svh"

module tsf_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] factor,
    input wire logic [2:0]  slip_index,
    input wire logic [14:0] phi_angle,
    input wire logic [14:0] lambda_angle
);

    `TSF_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(factor) && $stable(slip_index) && $stable(phi_angle) && $stable(lambda_angle), "result changed while stalled")
    `TSF_ASSERT(a_stall_blocks_in, clk, rst_n, out_valid && !out_ready |-> !in_ready, "input taken while output stalled")
    `TSF_ASSERT(a_result_range, clk, rst_n, out_valid |-> slip_index <= 3'd5 && phi_angle <= 15'd25736 && lambda_angle <= 15'd25736, "result field out of range")
    `TSF_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind trigonal_schmid_factor tsf_check u_tsf_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .factor       (factor),
    .slip_index   (slip_index),
    .phi_angle    (phi_angle),
    .lambda_angle (lambda_angle)
);

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the trigonal Schmid factor pipeline.
module tb_top;
    import tsf_pkg::*;

    typedef struct {
        logic [15:0] fac;
        logic [2:0]  idx;
        angle_t      phi;
        angle_t      lam;
    } schmid_t;

    typedef comp_t triple_set_t [9];

    localparam longint H = 32768;
    localparam longint R = 56756;
    localparam longint O = 65536;
    localparam longint OPS [6][9] = '{
        '{ O, 0, 0, 0, O, 0, 0, 0, O},
        '{-H, R, 0, -R, -H, 0, 0, 0, O},
        '{-H, -R, 0, R, -H, 0, 0, 0, O},
        '{ H, R, 0, R, -H, 0, 0, 0, -O},
        '{-O, 0, 0, 0, O, 0, 0, 0, -O},
        '{ H, -R, 0, -R, -H, 0, 0, 0, -O}
    };
    localparam longint ATAN_Q24 [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    comp_t       load_x, load_y, load_z;
    comp_t       plane_x, plane_y, plane_z;
    comp_t       dir_x, dir_y, dir_z;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] factor;
    logic [2:0]  slip_index;
    angle_t      phi_angle;
    angle_t      lambda_angle;

    schmid_t expected_q [$];
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      hold_req;
    int      hold_cnt;
    int      mismatches;
    int      quiet_cycles;

    trigonal_schmid_factor i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .load_x(load_x), .load_y(load_y), .load_z(load_z),
        .plane_x(plane_x), .plane_y(plane_y), .plane_z(plane_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .factor(factor), .slip_index(slip_index),
        .phi_angle(phi_angle), .lambda_angle(lambda_angle)
    );

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint trunc_shift(input longint v, input int s);
        return (v < 0) ? -((-v) >> s) : (v >> s);
    endfunction

    // Q1.30 cosine of a Q16 dot product over a magnitude product
    function automatic longint unsigned cos_q30(input longint dot, input longint unsigned p);
        longint unsigned c;
        if (p == 0) return 0;
        c = longint'(dot < 0 ? -dot : dot) << 14;
        c = c / p;
        return (c > (64'd1 << 30)) ? (64'd1 << 30) : c;
    endfunction

    function automatic angle_t arccos_q14(input longint unsigned c);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = longint'(c);
        y = longint'(int_sqrt((64'd1 << 60) - c * c));
        z = 0;
        for (int i = 0; i < 24; i++) begin
            xs = trunc_shift(x, i);
            ys = trunc_shift(y, i);
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + ATAN_Q24[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ATAN_Q24[i];
            end
        end
        if (z <= 0) return '0;
        z = (z + 512) >>> 10;
        return (z > 25736) ? angle_t'(25736) : angle_t'(z);
    endfunction

    // l . (M v) in Q16
    function automatic longint rotated_dot(input int op, input longint l [3],
                                           input longint v [3]);
        longint acc;
        acc = 0;
        for (int r = 0; r < 3; r++)
            acc += l[r] * (OPS[op][3*r] * v[0] + OPS[op][3*r+1] * v[1]
                           + OPS[op][3*r+2] * v[2]);
        return acc;
    endfunction

    function automatic schmid_t predict_schmid(input triple_set_t f);
        longint          l [3];
        longint          n [3];
        longint          d [3];
        longint unsigned ln, lp, ld, best, best_cp, best_cd, cp, cd, prod, fac;
        longint          pz;
        int              best_op;
        bit              found;
        schmid_t         res;
        for (int k = 0; k < 3; k++) begin
            l[k] = f[k];
            n[k] = f[3+k];
            d[k] = f[6+k];
        end
        ln = l[0]*l[0] + l[1]*l[1] + l[2]*l[2];
        lp = int_sqrt(ln * longint'(n[0]*n[0] + n[1]*n[1] + n[2]*n[2]));
        ld = int_sqrt(ln * longint'(d[0]*d[0] + d[1]*d[1] + d[2]*d[2]));
        best = 0; best_cp = 0; best_cd = 0; best_op = 0; found = 0;
        for (int op = 0; op < 6; op++) begin
            pz = OPS[op][6] * n[0] + OPS[op][7] * n[1] + OPS[op][8] * n[2];
            if (pz >= 0) begin
                cp   = cos_q30(rotated_dot(op, l, n), lp);
                cd   = cos_q30(rotated_dot(op, l, d), ld);
                prod = cp * cd;
                if (prod > best) begin
                    best = prod; best_op = op; best_cp = cp; best_cd = cd; found = 1;
                end
            end
        end
        fac = (best + (64'd1 << 43)) >> 44;
        res.fac = (fac > 65535) ? 16'hFFFF : fac[15:0];
        res.idx = best_op[2:0];
        res.phi = found ? arccos_q14(best_cp) : '0;
        res.lam = found ? arccos_q14(best_cd) : '0;
        return res;
    endfunction

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        out_ready = 0;
        hold_cnt  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 0;
                hold_cnt = HOLD_CYCLES;
                out_ready <= 0;
            end else if (hold_cnt > 0) begin
                hold_cnt--;
                out_ready <= 0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // result checker and watchdog
    initial
    begin
        schmid_t exp_r;
        mismatches   = 0;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("trigonal_schmid_factor: mismatch");
                $finish;
            end
            if (rst_n && out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result transfer");
                end else begin
                    exp_r = expected_q.pop_front();
                    if (factor !== exp_r.fac || slip_index !== exp_r.idx ||
                        phi_angle !== exp_r.phi || lambda_angle !== exp_r.lam) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("bad result: exp fac %0d idx %0d phi %0d lam %0d, got %0d %0d %0d %0d",
                                     exp_r.fac, exp_r.idx, exp_r.phi, exp_r.lam,
                                     factor, slip_index, phi_angle, lambda_angle);
                    end
                end
            end
        end
    end

    // Call at a rising edge; returns at the edge where the item transferred.
    task automatic send_item(input triple_set_t f);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        load_x  <= f[0]; load_y  <= f[1]; load_z  <= f[2];
        plane_x <= f[3]; plane_y <= f[4]; plane_z <= f[5];
        dir_x   <= f[6]; dir_y   <= f[7]; dir_z   <= f[8];
        do @(posedge clk); while (!in_ready);
        expected_q.insert(expected_q.size(), predict_schmid(f));
    endtask

    task automatic send_vectors(input comp_t lx, ly, lz, px, py, pz, dx, dy, dz);
        triple_set_t f;
        f = '{lx, ly, lz, px, py, pz, dx, dy, dz};
        send_item(f);
    endtask

    function automatic comp_t rand_comp(input int mode);
        case (mode)
            0: return comp_t'($urandom);
            1: return comp_t'($urandom_range(16) - 8);
            default: return ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    task automatic test_extremes();
        send_vectors(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                     16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_vectors(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                     16'sh8000, 16'sh8000, 16'sh8000);
        send_vectors(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                     16'sh8000, 16'sh7FFF, 16'sh8000);
        send_vectors(-1, -1, -1, 1, -1, 1, -1, 1, -1);
        send_vectors(16'sh7FFF, 0, 16'sh8000, 0, 16'sh7FFF, 16'sh8000, 16'sh8000, 0, 16'sh7FFF);
    endtask

    task automatic test_special_cases();
        // zero load, zero plane, zero direction
        send_vectors(0, 0, 0, 1, 2, 3, 4, 5, 6);
        send_vectors(1, 2, 3, 0, 0, 0, 4, 5, 6);
        send_vectors(1, 2, 3, 4, 5, 6, 0, 0, 0);
        // load normal to the plane under every operator: no positive factor
        send_vectors(0, 0, 5, 7, 0, 0, 0, 3, 0);
        // plane z zero: all six operators tried
        send_vectors(3, 5, 7, 2, -9, 0, 1, 4, -2);
        // all aligned with z: factor of one, ties between operators
        send_vectors(0, 0, 1, 0, 0, 1, 0, 0, 1);
        send_vectors(0, 0, -100, 0, 0, -100, 0, 0, 100);
        // plane z positive and negative
        send_vectors(10, -20, 30, 4, 5, 6, 6, -5, 4);
        send_vectors(10, -20, 30, 4, 5, -6, 6, -5, 4);
        // parallel vectors: cosine may overshoot one
        send_vectors(12345, -23456, 31111, 12345, -23456, 31111, 12345, -23456, 31111);
        send_vectors(1, 1, 1, 1, 1, 1, 1, 1, 1);
    endtask

    task automatic test_random_flow(input int idle_pct, input int stall_pct, input int count,
                                    input bit pressure);
        triple_set_t f;
        int          mode;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            if (pressure && i == 10) hold_req = 1;
            mode = $urandom_range(9);
            for (int k = 0; k < 9; k++)
                f[k] = rand_comp(mode < 6 ? 0 : (mode < 9 ? 1 : 2));
            if ($urandom_range(9) == 0) f[5] = 0;
            if ($urandom_range(19) == 0) begin
                mode = 3 * $urandom_range(2);
                f[mode] = 0; f[mode+1] = 0; f[mode+2] = 0;
            end
            send_item(f);
        end
    endtask

    initial
    begin
        rst_n          = 0;
        in_valid       = 0;
        hold_req       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        {load_x, load_y, load_z, plane_x, plane_y, plane_z, dir_x, dir_y, dir_z} = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_extremes();
        test_special_cases();
        test_random_flow(0, 0, 110, 1'b1);
        test_random_flow(78, 0, 110, 1'b0);
        test_random_flow(0, 78, 110, 1'b0);
        test_random_flow(7, 7, 110, 1'b0);
        in_valid <= 0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("trigonal_schmid_factor: match");
        else
            $display("trigonal_schmid_factor: mismatch");
        $finish;
    end

endmodule
